### src/sdhc_pkg.sv
// ----------------------------------------------------------------------------
// sdhc_pkg
// Shared types, register offsets and tables of the SD host register block.
// ----------------------------------------------------------------------------
`default_nettype none

package sdhc_pkg;

  localparam int unsigned FIFO_DEPTH = 128;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned CNT_FIELD_W = 13;  // status bits 17..29

  localparam int unsigned PLAIN_NUM = 24;
  localparam int unsigned PLAIN_IDX_W = 5;

  // item actions
  localparam logic [2:0] ACT_BUS_READ = 3'd0;
  localparam logic [2:0] ACT_BUS_WRITE = 3'd1;
  localparam logic [2:0] ACT_CARD_PUSH = 3'd2;
  localparam logic [2:0] ACT_CARD_PULL = 3'd3;
  localparam logic [2:0] ACT_CARD_RESP = 3'd4;

  // response kinds
  localparam logic [1:0] RESP_SHORT = 2'd1;
  localparam logic [1:0] RESP_LONG = 2'd2;

  // register offsets
  localparam logic [7:0] REG_CTRL = 8'h00;
  localparam logic [7:0] REG_BYTCNT = 8'h20;
  localparam logic [7:0] REG_INTMASK = 8'h24;
  localparam logic [7:0] REG_CMDARG = 8'h28;
  localparam logic [7:0] REG_CMD = 8'h2C;
  localparam logic [7:0] REG_RESP0 = 8'h30;
  localparam logic [7:0] REG_RESP1 = 8'h34;
  localparam logic [7:0] REG_RESP2 = 8'h38;
  localparam logic [7:0] REG_RESP3 = 8'h3C;
  localparam logic [7:0] REG_MINTSTS = 8'h40;
  localparam logic [7:0] REG_RINTSTS = 8'h44;
  localparam logic [7:0] REG_STATUS = 8'h48;
  localparam logic [7:0] REG_FIFOTH = 8'h4C;
  localparam logic [7:0] PLAIN_END = 8'hA0;
  localparam logic [11:0] FIFO_WINDOW = 12'h100;

  localparam logic [5:0] CMD_STOP = 6'd12;

  // raw interrupt bits
  localparam logic [31:0] INT_CMD_DONE = 32'h0000_0004;
  localparam logic [31:0] INT_DATA_DONE = 32'h0000_0008;
  localparam logic [31:0] INT_TXDR = 32'h0000_0010;
  localparam logic [31:0] INT_RXDR = 32'h0000_0020;
  localparam logic [31:0] INT_RESP_ERR = 32'h0000_0100;
  localparam logic [31:0] INT_FIFO_ERR = 32'h0000_0800;

  localparam logic [3:0] FLAGS_RESET = 4'b0110;

  typedef struct packed {
    logic [2:0] action;
    logic [11:0] address;
    logic [31:0] data_in;
    logic [1:0] resp_kind;
    logic [31:0] resp_word1;
    logic [31:0] resp_word2;
    logic [31:0] resp_word3;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic irq;
    logic cmd_issue;
    logic [5:0] cmd_index;
    logic [31:0] cmd_argument;
    logic [31:0] card_word_out;
    logic card_word_valid;
    logic card_data_wanted;
    logic card_power;
  } out_item_t;

  // Word slot to plain register: bit 7 writable, bits 6..0 index plus one.
  function automatic logic [7:0] plain_map(input logic [5:0] slot);
    logic [7:0] m;
    m = 8'h00;
    case (slot)
      6'd1: m = 8'h81;
      6'd2: m = 8'h82;
      6'd3: m = 8'h83;
      6'd4: m = 8'h84;
      6'd5: m = 8'h85;
      6'd6: m = 8'h86;
      6'd7: m = 8'h87;
      6'd20: m = 8'h88;
      6'd21: m = 8'h09;
      6'd22: m = 8'h8A;
      6'd23: m = 8'h0B;
      6'd24: m = 8'h0C;
      6'd25: m = 8'h8D;
      6'd26: m = 8'h8E;
      6'd27: m = 8'h0F;
      6'd28: m = 8'h10;
      6'd32: m = 8'h11;
      6'd33: m = 8'h92;
      6'd34: m = 8'h93;
      6'd35: m = 8'h94;
      6'd36: m = 8'h95;
      6'd37: m = 8'h16;
      6'd38: m = 8'h17;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] plain_reset(input logic [PLAIN_IDX_W-1:0] idx);
    logic [31:0] v;
    v = 32'h0;
    case (idx)
      5'd4: v = 32'hffff_ff40;
      5'd6: v = 32'h0000_0200;
      5'd7: v = 32'hffff_fffe;
      5'd12: v = 32'h00ff_ffff;
      5'd15: v = 32'h0079_2cc3;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### src/sdhc_in_if.sv
// ----------------------------------------------------------------------------
// sdhc_in_if
// Valid/ready channel carrying one bus or card item.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdhc_in_if;
  logic valid;
  logic ready;
  sdhc_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### src/sdhc_out_if.sv
// ----------------------------------------------------------------------------
// sdhc_out_if
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdhc_out_if;
  logic valid;
  logic ready;
  sdhc_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### src/sd_host_controller_fifo_regs.sv
// ----------------------------------------------------------------------------
// sd_host_controller_fifo_regs
// SD host register block with a word-wide data FIFO held in a synchronous RAM.
// ----------------------------------------------------------------------------
//  channel | dir | transfer meaning
//  --------+-----+---------------------------------------------------------
//  in_i    | in  | one bus read/write, card push/pull or card response
//  out_o   | out | one result per input transfer
//
//  Each accepted transfer's result is registered and shown in the next cycle.
//  All register state updates at the accepting edge; the FIFO RAM read issued
//  at that edge supplies the data word from its output register with the result.
//  A new transfer is taken while the result register is empty or being drained,
//  so the block sustains one transfer per cycle; a stalled output holds input.
//  Reset sets the state registers to reset values; FIFO RAM needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module sd_host_controller_fifo_regs (
  input wire logic clk_i,
  input wire logic rst_ni,
  sdhc_in_if.sink in_i,
  sdhc_out_if.source out_o
);

  localparam int unsigned PW = sdhc_pkg::FIFO_PTR_W;
  localparam int unsigned CW = sdhc_pkg::FIFO_CNT_W;

  // Architectural registers
  logic [31:0] ctrl_q, ctrl_d;
  logic [31:0] cmd_q, cmd_d;
  logic [31:0] arg_q, arg_d;
  logic [31:0] bc_q, bc_d;
  logic [31:0] mask_q, mask_d;
  logic [31:0] raw_q, raw_d;
  logic [31:0] masked_q, masked_d;
  logic [31:0] wm_q, wm_d;
  logic [3:0] flags_q, flags_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] head_q, head_d;
  logic [31:0] resp_q [4];
  logic [31:0] resp_d [4];
  logic [31:0] plain_q [sdhc_pkg::PLAIN_NUM];

  // FIFO RAM
  logic [31:0] fifo_mem [sdhc_pkg::FIFO_DEPTH];
  logic [31:0] mem_rdata_q;
  logic fifo_we;
  logic [PW-1:0] fifo_waddr;

  // Result register
  logic out_valid_q;
  sdhc_pkg::out_item_t res_q, res_d;
  logic use_mem_rd_q, use_mem_rd_d;
  logic use_mem_pull_q, use_mem_pull_d;

  logic accept;
  sdhc_pkg::in_item_t it;

  // Plain register access
  logic [7:0] pm;
  logic [sdhc_pkg::PLAIN_IDX_W-1:0] plain_idx;
  logic plain_we;
  logic in_plain;

  logic [11:0] rxwm, txwm;
  logic [CW-1:0] wcnt;
  logic upd, remask, flush;
  logic [sdhc_pkg::CNT_FIELD_W-1:0] cnt_field;

  assign it = in_i.payload;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept = in_i.valid && in_i.ready;

  assign pm = sdhc_pkg::plain_map(it.address[7:2]);
  assign plain_idx = sdhc_pkg::PLAIN_IDX_W'(pm[6:0] - 7'd1);
  assign in_plain = (it.address[7:0] < sdhc_pkg::PLAIN_END) && (pm != 8'h00);
  assign rxwm = wm_q[27:16];
  assign txwm = wm_q[11:0];
  assign cnt_field = sdhc_pkg::CNT_FIELD_W'(cnt_q);

  always_comb begin
    ctrl_d = ctrl_q;
    cmd_d = cmd_q;
    arg_d = arg_q;
    bc_d = bc_q;
    mask_d = mask_q;
    raw_d = raw_q;
    masked_d = masked_q;
    wm_d = wm_q;
    flags_d = flags_q;
    cnt_d = cnt_q;
    head_d = head_q;
    resp_d = resp_q;
    res_d = '0;
    use_mem_rd_d = 1'b0;
    use_mem_pull_d = 1'b0;
    fifo_we = 1'b0;
    fifo_waddr = PW'(head_q + PW'(cnt_q));
    plain_we = 1'b0;
    upd = 1'b0;
    remask = 1'b0;
    flush = 1'b0;
    wcnt = '0;

    unique case (it.action)
      sdhc_pkg::ACT_BUS_READ: begin
        if (it.address >= sdhc_pkg::FIFO_WINDOW) begin
          if (flags_q[2]) begin
            // underrun: flag and return zero
            raw_d = raw_q | sdhc_pkg::INT_FIFO_ERR;
            remask = 1'b1;
          end else begin
            use_mem_rd_d = 1'b1;
            head_d = head_q + PW'(1);
            cnt_d = cnt_q - CW'(1);
            upd = 1'b1;
          end
        end else if (it.address[1:0] != 2'b00) begin
          res_d.read_data = '1;
        end else begin
          unique case (it.address[7:0])
            sdhc_pkg::REG_CTRL: res_d.read_data = ctrl_q;
            sdhc_pkg::REG_BYTCNT: res_d.read_data = bc_q;
            sdhc_pkg::REG_INTMASK: res_d.read_data = mask_q;
            sdhc_pkg::REG_CMDARG: res_d.read_data = arg_q;
            sdhc_pkg::REG_CMD: res_d.read_data = cmd_q;
            sdhc_pkg::REG_RESP0: res_d.read_data = resp_q[0];
            sdhc_pkg::REG_RESP1: res_d.read_data = resp_q[1];
            sdhc_pkg::REG_RESP2: res_d.read_data = resp_q[2];
            sdhc_pkg::REG_RESP3: res_d.read_data = resp_q[3];
            sdhc_pkg::REG_MINTSTS: res_d.read_data = masked_q;
            sdhc_pkg::REG_RINTSTS: res_d.read_data = raw_q;
            sdhc_pkg::REG_STATUS:
              res_d.read_data = {2'b00, cnt_field, 8'h00, 1'b1, 4'h0, flags_q};
            sdhc_pkg::REG_FIFOTH: res_d.read_data = wm_q;
            default: res_d.read_data = in_plain ? plain_q[plain_idx] : '1;
          endcase
        end
      end
      sdhc_pkg::ACT_BUS_WRITE: begin
        if (it.address >= sdhc_pkg::FIFO_WINDOW) begin
          if (flags_q[3]) begin
            // overrun: flag and drop the word
            raw_d = raw_q | sdhc_pkg::INT_FIFO_ERR;
            remask = 1'b1;
          end else begin
            fifo_we = 1'b1;
            cnt_d = cnt_q + CW'(1);
            upd = 1'b1;
          end
        end else if (it.address[1:0] == 2'b00) begin
          unique case (it.address[7:0])
            sdhc_pkg::REG_CTRL: begin
              ctrl_d = it.data_in & ~32'h3;
              flush = it.data_in[1];
              upd = 1'b1;
            end
            sdhc_pkg::REG_BYTCNT: bc_d = it.data_in;
            sdhc_pkg::REG_INTMASK: mask_d = it.data_in;
            sdhc_pkg::REG_CMDARG: arg_d = it.data_in;
            sdhc_pkg::REG_CMD: begin
              cmd_d = it.data_in & ~32'h8000_0000;
              for (int i = 0; i < 4; i++) resp_d[i] = '0;
              if (!it.data_in[21]) begin
                res_d.cmd_issue = 1'b1;
                res_d.cmd_index = it.data_in[5:0];
                res_d.cmd_argument = arg_q;
              end
              upd = 1'b1;
            end
            sdhc_pkg::REG_RINTSTS: begin
              raw_d = raw_q & ~it.data_in;
              remask = 1'b1;
            end
            sdhc_pkg::REG_FIFOTH: wm_d = it.data_in;
            default: plain_we = in_plain && pm[7];
          endcase
        end
      end
      sdhc_pkg::ACT_CARD_PUSH: begin
        if (cmd_q[9] && !cmd_q[10] && !flags_q[3] && bc_q != 32'h0) begin
          fifo_we = 1'b1;
          cnt_d = cnt_q + CW'(1);
          bc_d = (bc_q > 32'd4) ? bc_q - 32'd4 : 32'h0;
          res_d.card_word_valid = 1'b1;
          upd = 1'b1;
        end
      end
      sdhc_pkg::ACT_CARD_PULL: begin
        if (cmd_q[9] && cmd_q[10] && !flags_q[2] && bc_q != 32'h0) begin
          use_mem_pull_d = 1'b1;
          head_d = head_q + PW'(1);
          cnt_d = cnt_q - CW'(1);
          bc_d = (bc_q > 32'd4) ? bc_q - 32'd4 : 32'h0;
          res_d.card_word_valid = 1'b1;
          upd = 1'b1;
        end
      end
      sdhc_pkg::ACT_CARD_RESP: begin
        if (cmd_q[6]) begin
          if (it.resp_kind == sdhc_pkg::RESP_SHORT && !cmd_q[7]) begin
            resp_d[0] = it.data_in;
            resp_d[1] = '0;
            resp_d[2] = '0;
            resp_d[3] = '0;
          end else if (it.resp_kind == sdhc_pkg::RESP_LONG && cmd_q[7]) begin
            resp_d[0] = it.data_in;
            resp_d[1] = it.resp_word1;
            resp_d[2] = it.resp_word2;
            resp_d[3] = it.resp_word3;
          end else begin
            raw_d = raw_d | sdhc_pkg::INT_RESP_ERR;
          end
        end
        if (cmd_q[12]) begin
          // auto stop
          res_d.cmd_issue = 1'b1;
          res_d.cmd_index = sdhc_pkg::CMD_STOP;
          res_d.cmd_argument = arg_q;
        end
        raw_d = raw_d | sdhc_pkg::INT_CMD_DONE;
        remask = 1'b1;
      end
      default: ;
    endcase

    // Level and completion update after any FIFO, command or control change
    if (upd) begin
      remask = 1'b1;
      if (cmd_d[9] && bc_d == 32'h0) raw_d = raw_d | sdhc_pkg::INT_DATA_DONE;
      if (flush) begin
        head_d = '0;
        cnt_d = '0;
        flags_d = sdhc_pkg::FLAGS_RESET;
        raw_d = raw_d | sdhc_pkg::INT_TXDR;
      end else begin
        wcnt = cnt_d;
        flags_d[2] = (wcnt == '0);
        flags_d[3] = (wcnt == CW'(sdhc_pkg::FIFO_DEPTH));
        flags_d[0] = (12'(wcnt) > rxwm);
        flags_d[1] = (12'(wcnt) <= txwm);
        if (flags_d[0] && !cmd_d[10]) raw_d = raw_d | sdhc_pkg::INT_RXDR;
        if (flags_d[1] && cmd_d[10]) raw_d = raw_d | sdhc_pkg::INT_TXDR;
      end
    end
    if (remask) masked_d = raw_d & mask_d;

    res_d.irq = (masked_d != 32'h0) && ctrl_d[4];
    res_d.card_data_wanted = cmd_d[9] && (bc_d != 32'h0);
    res_d.card_power = (plain_we && plain_idx == '0) ? it.data_in[0] : plain_q[0][0];
  end

  // Hold state; advance on a transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
      cmd_q <= '0;
      arg_q <= '0;
      bc_q <= 32'h200;
      mask_q <= '0;
      raw_q <= '0;
      masked_q <= '0;
      wm_q <= '0;
      flags_q <= sdhc_pkg::FLAGS_RESET;
      cnt_q <= '0;
      head_q <= '0;
      for (int i = 0; i < 4; i++) resp_q[i] <= '0;
      for (int i = 0; i < sdhc_pkg::PLAIN_NUM; i++) begin
        plain_q[i] <= sdhc_pkg::plain_reset(sdhc_pkg::PLAIN_IDX_W'(i));
      end
      out_valid_q <= 1'b0;
      use_mem_rd_q <= 1'b0;
      use_mem_pull_q <= 1'b0;
    end else begin
      if (accept) begin
        ctrl_q <= ctrl_d;
        cmd_q <= cmd_d;
        arg_q <= arg_d;
        bc_q <= bc_d;
        mask_q <= mask_d;
        raw_q <= raw_d;
        masked_q <= masked_d;
        wm_q <= wm_d;
        flags_q <= flags_d;
        cnt_q <= cnt_d;
        head_q <= head_d;
        resp_q <= resp_d;
        if (plain_we) plain_q[plain_idx] <= it.data_in;
        use_mem_rd_q <= use_mem_rd_d;
        use_mem_pull_q <= use_mem_pull_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) res_q <= res_d;
  end

  // FIFO RAM: one write and one registered read per cycle, on accepted transfers only
  always_ff @(posedge clk_i) begin
    if (accept && fifo_we) fifo_mem[fifo_waddr] <= it.data_in;
    if (accept) mem_rdata_q <= fifo_mem[head_q];
  end

  always_comb begin
    out_o.payload = res_q;
    if (use_mem_rd_q) out_o.payload.read_data = mem_rdata_q;
    if (use_mem_pull_q) out_o.payload.card_word_out = mem_rdata_q;
  end
  assign out_o.valid = out_valid_q;

endmodule

`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SD host register block. Bus reads and writes,
// card word pushes and pulls and card responses are driven on the input
// channel. Every result is compared field by field with a cycle-free model of
// the registers, interrupt status and data FIFO kept inside the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import sdhc_pkg::*;

  // Control, command and status bits used by the model
  localparam logic [31:0] CTRL_FIFO_RST = 32'h0000_0002;
  localparam logic [31:0] CTRL_INT_EN = 32'h0000_0010;
  localparam logic [31:0] CMD_RESP_EXP = 32'h0000_0040;
  localparam logic [31:0] CMD_RESP_LONG = 32'h0000_0080;
  localparam logic [31:0] CMD_DATA_EXP = 32'h0000_0200;
  localparam logic [31:0] CMD_TO_CARD = 32'h0000_0400;
  localparam logic [31:0] CMD_AUTO_STOP = 32'h0000_1000;
  localparam logic [31:0] CMD_NO_SEND = 32'h0020_0000;
  localparam logic [31:0] CMD_START = 32'h8000_0000;
  localparam logic [31:0] STS_RX_WM = 32'h0000_0001;
  localparam logic [31:0] STS_TX_WM = 32'h0000_0002;
  localparam logic [31:0] STS_EMPTY = 32'h0000_0004;
  localparam logic [31:0] STS_FULL = 32'h0000_0008;
  localparam logic [11:0] ADDR_POW_EN = 12'h004;
  localparam logic [2:0] ACT_UNUSED = 3'd7;
  localparam logic [1:0] RESP_NONE = 2'd0;
  localparam logic [1:0] RESP_BAD = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RANDOM_ITEMS = 1700;

  // Word slot to plain register: bit 7 writable, low bits index plus one
  localparam logic [7:0] SLOT_TABLE [40] = '{
    8'h00, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h88, 8'h09, 8'h8A, 8'h0B,
    8'h0C, 8'h8D, 8'h8E, 8'h0F, 8'h10, 8'h00, 8'h00, 8'h00,
    8'h11, 8'h92, 8'h93, 8'h94, 8'h95, 8'h16, 8'h17, 8'h00};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sdhc_in_if in_bus ();
  sdhc_out_if out_bus ();

  sd_host_controller_fifo_regs i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always #10 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Register and FIFO model
  // --------------------------------------------------------------------------
  logic [31:0] m_ctrl, m_cmd, m_arg, m_bytes, m_mask, m_raw, m_masked;
  logic [31:0] m_status, m_wmark;
  logic [31:0] m_resp [4];
  logic [31:0] m_fifo [FIFO_DEPTH];
  logic [6:0] m_head;
  logic [31:0] m_plain [PLAIN_NUM];

  out_item_t expected_q[$];
  logic [32:0] pinned_q[$];  // bit 32: pinned flag; 31..0: typed-in read value
  int unsigned n_errors = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned n_words = 0;
  int unsigned n_cmds = 0;
  int unsigned n_fifo_err = 0;
  int unsigned cycles = 0;
  bit long_hold_done = 1'b0;

  function void model_reset();
    m_ctrl = '0; m_cmd = '0; m_arg = '0; m_bytes = 32'h200;
    m_mask = '0; m_raw = '0; m_masked = '0; m_status = 32'h106; m_wmark = '0;
    m_head = '0;
    for (int i = 0; i < 4; i++) m_resp[i] = '0;
    for (int i = 0; i < PLAIN_NUM; i++) m_plain[i] = '0;
    m_plain[4] = 32'hffff_ff40;
    m_plain[6] = 32'h0000_0200;
    m_plain[7] = 32'hffff_fffe;
    m_plain[12] = 32'h00ff_ffff;
    m_plain[15] = 32'h0079_2cc3;
  endfunction

  function int fill_level();
    return int'(m_status[29:17]);
  endfunction

  function void set_level(int c);
    m_status[29:17] = c[12:0];
  endfunction

  function void refresh_masked();
    m_masked = m_raw & m_mask;
  endfunction

  // Refresh empty/full/watermark flags and level interrupts, or do a FIFO reset
  function void refresh_levels();
    int cnt;
    int rx_mark;
    int tx_mark;
    bit to_card;
    cnt = fill_level();
    rx_mark = int'(m_wmark[27:16]);
    tx_mark = int'(m_wmark[11:0]);
    to_card = (m_cmd & CMD_TO_CARD) != 0;
    if (m_ctrl & CTRL_FIFO_RST) begin
      m_head = '0;
      set_level(0);
      m_status = (m_status | STS_EMPTY | STS_TX_WM) & ~(STS_RX_WM | STS_FULL);
      m_raw |= INT_TXDR;
      refresh_masked();
      return;
    end
    if (cnt == 0) m_status |= STS_EMPTY; else m_status &= ~STS_EMPTY;
    if (cnt == FIFO_DEPTH) m_status |= STS_FULL; else m_status &= ~STS_FULL;
    if (cnt > rx_mark && !to_card) m_raw |= INT_RXDR;
    if (cnt <= tx_mark && to_card) m_raw |= INT_TXDR;
    refresh_masked();
    if (cnt > rx_mark) m_status |= STS_RX_WM; else m_status &= ~STS_RX_WM;
    if (cnt <= tx_mark) m_status |= STS_TX_WM; else m_status &= ~STS_TX_WM;
  endfunction

  function void refresh_all();
    if ((m_cmd & CMD_DATA_EXP) && m_bytes == 0) begin
      m_raw |= INT_DATA_DONE;
      refresh_masked();
    end
    refresh_levels();
  endfunction

  function void consume_bytes();
    m_bytes = (m_bytes > 4) ? m_bytes - 4 : '0;
  endfunction

  function void fifo_err();
    m_raw |= INT_FIFO_ERR;
    refresh_masked();
    n_fifo_err++;
  endfunction

  function logic [31:0] reg_read(logic [11:0] addr);
    logic [31:0] v;
    logic [7:0] slot;
    int cnt;
    if (addr >= FIFO_WINDOW) begin
      if (m_status & STS_EMPTY) begin
        fifo_err();
        return '0;
      end
      cnt = fill_level();
      v = m_fifo[m_head];
      m_head = m_head + 7'd1;
      set_level(cnt - 1);
      refresh_all();
      return v;
    end
    if (addr[1:0] != 2'b00) return '1;
    case (addr[7:0])
      REG_CTRL: return m_ctrl;
      REG_BYTCNT: return m_bytes;
      REG_INTMASK: return m_mask;
      REG_CMDARG: return m_arg;
      REG_CMD: return m_cmd;
      REG_RESP0, REG_RESP1, REG_RESP2, REG_RESP3: return m_resp[addr[3:2]];
      REG_MINTSTS: return m_masked;
      REG_RINTSTS: return m_raw;
      REG_STATUS: return m_status;
      REG_FIFOTH: return m_wmark;
      default: ;
    endcase
    if (addr < 12'(PLAIN_END)) begin
      slot = SLOT_TABLE[addr[7:2]];
      if (slot != 0) return m_plain[slot[6:0] - 1];
    end
    return '1;
  endfunction

  function void reg_write(logic [11:0] addr, logic [31:0] value, inout out_item_t o);
    logic [7:0] slot;
    int cnt;
    if (addr >= FIFO_WINDOW) begin
      if (m_status & STS_FULL) begin
        fifo_err();
        return;
      end
      cnt = fill_level();
      m_fifo[7'(m_head + cnt)] = value;
      set_level(cnt + 1);
      refresh_all();
      return;
    end
    if (addr[1:0] != 2'b00) return;
    case (addr[7:0])
      REG_CTRL: begin
        m_ctrl = value;
        refresh_all();
        m_ctrl &= ~32'h3;
        return;
      end
      REG_BYTCNT: begin m_bytes = value; return; end
      REG_INTMASK: begin m_mask = value; return; end
      REG_CMDARG: begin m_arg = value; return; end
      REG_CMD: begin
        m_cmd = value;
        for (int i = 0; i < 4; i++) m_resp[i] = '0;
        if (!(m_cmd & CMD_NO_SEND)) begin
          o.cmd_issue = 1'b1;
          o.cmd_index = m_cmd[5:0];
          o.cmd_argument = m_arg;
        end
        m_cmd &= ~CMD_START;
        refresh_all();
        return;
      end
      REG_RINTSTS: begin
        m_raw &= ~value;
        refresh_masked();
        return;
      end
      REG_FIFOTH: begin m_wmark = value; return; end
      default: ;
    endcase
    if (addr < 12'(PLAIN_END)) begin
      slot = SLOT_TABLE[addr[7:2]];
      if (slot[7]) m_plain[slot[6:0] - 1] = value;
    end
  endfunction

  function void take_response(in_item_t it, inout out_item_t o);
    bit is_long;
    is_long = (m_cmd & CMD_RESP_LONG) != 0;
    if (m_cmd & CMD_RESP_EXP) begin
      if (it.resp_kind == RESP_SHORT && !is_long) begin
        m_resp[0] = it.data_in;
        m_resp[1] = '0; m_resp[2] = '0; m_resp[3] = '0;
      end else if (it.resp_kind == RESP_LONG && is_long) begin
        m_resp[0] = it.data_in;
        m_resp[1] = it.resp_word1;
        m_resp[2] = it.resp_word2;
        m_resp[3] = it.resp_word3;
      end else begin
        m_raw |= INT_RESP_ERR;
      end
    end
    if (m_cmd & CMD_AUTO_STOP) begin
      o.cmd_issue = 1'b1;
      o.cmd_index = CMD_STOP;
      o.cmd_argument = m_arg;
    end
    m_raw |= INT_CMD_DONE;
    refresh_masked();
  endfunction

  // Advance the model by one item and return the result it produces
  function out_item_t predict_result(in_item_t it);
    out_item_t o;
    int cnt;
    bit data_on;
    bit to_card;
    o = '0;
    cnt = fill_level();
    data_on = (m_cmd & CMD_DATA_EXP) != 0;
    to_card = (m_cmd & CMD_TO_CARD) != 0;
    case (it.action)
      ACT_BUS_READ: o.read_data = reg_read(it.address);
      ACT_BUS_WRITE: reg_write(it.address, it.data_in, o);
      ACT_CARD_PUSH: begin
        if (data_on && !to_card && cnt < FIFO_DEPTH && m_bytes != 0) begin
          m_fifo[7'(m_head + cnt)] = it.data_in;
          set_level(cnt + 1);
          consume_bytes();
          o.card_word_valid = 1'b1;
          refresh_all();
        end
      end
      ACT_CARD_PULL: begin
        if (data_on && to_card && cnt > 0 && m_bytes != 0) begin
          o.card_word_out = m_fifo[m_head];
          m_head = m_head + 7'd1;
          set_level(cnt - 1);
          consume_bytes();
          o.card_word_valid = 1'b1;
          refresh_all();
        end
      end
      ACT_CARD_RESP: take_response(it, o);
      default: ;
    endcase
    o.irq = (m_masked != 0) && ((m_ctrl & CTRL_INT_EN) != 0);
    o.card_data_wanted = ((m_cmd & CMD_DATA_EXP) != 0) && (m_bytes != 0);
    o.card_power = m_plain[0][0];
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Monitors: predict on every input transfer, check every output transfer
  // --------------------------------------------------------------------------
  function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
      n_errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    out_item_t exp_r;
    out_item_t got;
    logic [32:0] pin;
    if (rst_ni && in_bus.valid && in_bus.ready) begin
      exp_r = predict_result(in_bus.payload);
      n_accepted++;
      if (exp_r.card_word_valid) n_words++;
      if (exp_r.cmd_issue) n_cmds++;
      // Hold the typed-in read values of the directed table against the model
      if (pinned_q.size() > 0) begin
        pin = pinned_q.pop_front();
        if (pin[32] && pin[31:0] !== exp_r.read_data) begin
          $display("%0t: mismatch table read_data expected %h actual %h",
                   $time, pin[31:0], exp_r.read_data);
          n_errors++;
        end
      end
      expected_q.push_back(exp_r);
    end
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got = out_bus.payload;
      n_results++;
      if (expected_q.size() == 0) begin
        $display("%0t: mismatch result with none pending expected none actual %h",
                 $time, got);
        n_errors++;
      end else begin
        exp_r = expected_q.pop_front();
        check_field("read_data", exp_r.read_data, got.read_data);
        check_field("irq", 32'(exp_r.irq), 32'(got.irq));
        check_field("cmd_issue", 32'(exp_r.cmd_issue), 32'(got.cmd_issue));
        check_field("cmd_index", 32'(exp_r.cmd_index), 32'(got.cmd_index));
        check_field("cmd_argument", exp_r.cmd_argument, got.cmd_argument);
        check_field("card_word_out", exp_r.card_word_out, got.card_word_out);
        check_field("card_word_valid", 32'(exp_r.card_word_valid),
                    32'(got.card_word_valid));
        check_field("card_data_wanted", 32'(exp_r.card_data_wanted),
                    32'(got.card_data_wanted));
        check_field("card_power", 32'(exp_r.card_power), 32'(got.card_power));
      end
    end
  end

  // Watchdog: end the run if the block hangs
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results pending", $time, expected_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random stalls, plus one long hold-off to back up the input
  // --------------------------------------------------------------------------
  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  initial begin
    int stall;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!long_hold_done && n_accepted > 400) begin
        // Hold off long enough for the sender to back up into the block
        long_hold_done = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
      end
      stall = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_bus.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  bit quiet_phase = 1'b0;  // stretches with no gaps at all

  // Offer one item; drop valid only when a gap is inserted
  task automatic send(in_item_t it);
    int gap;
    gap = quiet_phase ? 0 : gap_len();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.payload <= it;
    do @(posedge clk_i); while (!in_bus.ready);
    @(negedge clk_i);
  endtask

  function in_item_t make_item(logic [2:0] act, logic [11:0] addr, logic [31:0] data);
    in_item_t it;
    it.action = act;
    it.address = addr;
    it.data_in = data;
    it.resp_kind = 2'($urandom_range(0, 3));
    it.resp_word1 = $urandom;
    it.resp_word2 = $urandom;
    it.resp_word3 = $urandom;
    return it;
  endfunction

  task automatic wr(logic [11:0] addr, logic [31:0] data);
    send(make_item(ACT_BUS_WRITE, addr, data));
  endtask

  task automatic rd(logic [11:0] addr);
    send(make_item(ACT_BUS_READ, addr, $urandom));
  endtask

  function logic [11:0] window_addr();
    return 12'($urandom_range(int'(FIFO_WINDOW), 4095));
  endfunction

  function logic [11:0] any_reg_addr();
    return 12'($urandom_range(0, 40) * 4);
  endfunction

  // Directed table: item plus optional typed-in read value
  typedef struct {
    in_item_t it;
    bit pinned;
    logic [31:0] rd_val;
  } row_t;
  row_t table_rows[$];

  function void add_row(logic [2:0] act, logic [11:0] addr, logic [31:0] data,
                        logic [1:0] kind, bit pinned, logic [31:0] rd_val);
    row_t r;
    r.it = make_item(act, addr, data);
    r.it.resp_kind = kind;
    r.pinned = pinned;
    r.rd_val = rd_val;
    table_rows.push_back(r);
  endfunction

  task automatic card_in_burst();
    int n;
    n = $urandom_range(1, 40);
    wr(12'(REG_BYTCNT), 32'(n * 4 - $urandom_range(0, 3)));
    wr(12'(REG_CMD), CMD_DATA_EXP | CMD_START | ($urandom & 32'h0000_10ff));
    for (int i = 0; i < n + 2; i++) begin
      if ($urandom_range(0, 3) == 0) rd(window_addr());
      send(make_item(ACT_CARD_PUSH, 12'($urandom), $urandom));
    end
    for (int i = 0; i < n + 1; i++) rd(window_addr());
    rd(12'(REG_RINTSTS));
  endtask

  task automatic card_out_burst();
    int n;
    n = $urandom_range(1, 40);
    wr(12'(REG_BYTCNT), 32'(n * 4 - $urandom_range(0, 3)));
    wr(12'(REG_CMD), CMD_DATA_EXP | CMD_TO_CARD | ($urandom & 32'h0020_10ff));
    for (int i = 0; i < n; i++) wr(window_addr(), $urandom);
    for (int i = 0; i < n + 2; i++) send(make_item(ACT_CARD_PULL, 12'($urandom), $urandom));
    rd(12'(REG_STATUS));
  endtask

  task automatic fill_and_drain();
    int n;
    n = $urandom_range(FIFO_DEPTH - 2, FIFO_DEPTH + 3);
    quiet_phase = $urandom_range(0, 1);
    for (int i = 0; i < n; i++) wr(window_addr(), $urandom);
    rd(12'(REG_STATUS));
    for (int i = 0; i < n + 1; i++) rd(window_addr());
    quiet_phase = 1'b0;
  endtask

  task automatic command_exchange();
    logic [1:0] kind;
    in_item_t it;
    wr(12'(REG_CMDARG), $urandom);
    wr(12'(REG_CMD), $urandom & (32'h8020_10ff | CMD_RESP_EXP | CMD_RESP_LONG));
    kind = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3))
                                       : ($urandom_range(0, 1) ? RESP_LONG : RESP_SHORT);
    it = make_item(ACT_CARD_RESP, 12'($urandom), $urandom);
    it.resp_kind = kind;
    send(it);
    for (int i = 0; i < 4; i++) rd(12'(REG_RESP0) + 12'(i * 4));
    rd(12'(REG_MINTSTS));
    if (kind == RESP_NONE) rd(12'(REG_RINTSTS));
  endtask

  task automatic register_poke();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: wr(12'(REG_CTRL), ($urandom & 32'hffff_ffef) | ($urandom_range(0, 3) != 0
             ? CTRL_INT_EN : 32'h0));
      1: wr(12'(REG_INTMASK), $urandom_range(0, 1) ? 32'hffff_ffff : $urandom);
      2: wr(12'(REG_RINTSTS), $urandom);
      3: wr(12'(REG_FIFOTH), $urandom & 32'h0fff_0fff);
      4: wr(any_reg_addr(), $urandom);
      5: wr(ADDR_POW_EN, $urandom);
      6: wr(12'(REG_CTRL), CTRL_FIFO_RST | CTRL_INT_EN);
      default: rd(any_reg_addr());
    endcase
  endtask

  task automatic noise_item();
    send(make_item(3'($urandom_range(0, 7)), 12'($urandom), $urandom));
  endtask

  initial begin
    int first_accepted;
    in_bus.valid = 1'b0;
    in_bus.payload = '0;
    model_reset();

    // Power-on values, bad addresses, underrun, then one pass over every action
    add_row(ACT_BUS_READ, 12'(REG_CTRL), '0, RESP_NONE, 1, 32'h0);
    add_row(ACT_BUS_READ, 12'(REG_BYTCNT), '0, RESP_NONE, 1, 32'h200);
    add_row(ACT_BUS_READ, 12'(REG_STATUS), '0, RESP_NONE, 1, 32'h106);
    add_row(ACT_BUS_READ, 12'h070, '0, RESP_NONE, 1, 32'h0079_2cc3);
    add_row(ACT_BUS_READ, 12'h002, '0, RESP_NONE, 1, 32'hffff_ffff);
    add_row(ACT_BUS_READ, 12'h0fc, '0, RESP_NONE, 1, 32'hffff_ffff);
    add_row(ACT_BUS_READ, 12'hfff, '0, RESP_NONE, 1, 32'h0);
    add_row(ACT_BUS_READ, 12'(REG_RINTSTS), '0, RESP_NONE, 1, INT_FIFO_ERR);
    add_row(ACT_BUS_WRITE, 12'(REG_INTMASK), '1, RESP_NONE, 0, '0);
    add_row(ACT_BUS_WRITE, 12'(REG_CTRL), CTRL_INT_EN, RESP_NONE, 0, '0);
    add_row(ACT_BUS_WRITE, 12'(REG_RINTSTS), '1, RESP_NONE, 0, '0);
    add_row(ACT_BUS_WRITE, ADDR_POW_EN, 32'h1, RESP_NONE, 0, '0);
    add_row(ACT_BUS_WRITE, 12'(REG_CMDARG), 32'hdead_beef, RESP_NONE, 0, '0);
    add_row(ACT_BUS_WRITE, 12'(REG_CMD),
            CMD_START | CMD_AUTO_STOP | CMD_DATA_EXP | CMD_RESP_EXP | 32'h3f,
            RESP_NONE, 0, '0);
    add_row(ACT_CARD_PUSH, '0, '1, RESP_NONE, 0, '0);
    add_row(ACT_CARD_PUSH, '1, '0, RESP_NONE, 0, '0);
    add_row(ACT_CARD_RESP, '0, 32'h1234_5678, RESP_SHORT, 0, '0);
    add_row(ACT_BUS_READ, 12'(REG_RESP0), '0, RESP_NONE, 1, 32'h1234_5678);
    add_row(ACT_CARD_RESP, '0, '1, RESP_BAD, 0, '0);
    add_row(ACT_BUS_READ, 12'h100, '0, RESP_NONE, 1, 32'hffff_ffff);
    add_row(ACT_BUS_WRITE, 12'(REG_CMD), CMD_NO_SEND | CMD_TO_CARD | CMD_DATA_EXP,
            RESP_NONE, 0, '0);
    add_row(ACT_CARD_PULL, '0, '0, RESP_NONE, 0, '0);
    add_row(ACT_BUS_WRITE, 12'(REG_FIFOTH), 32'h0fff_0fff, RESP_NONE, 0, '0);
    add_row(ACT_BUS_WRITE, 12'(REG_CTRL), CTRL_FIFO_RST | CTRL_INT_EN, RESP_NONE, 0, '0);
    add_row(ACT_UNUSED, '1, '1, RESP_BAD, 0, '0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (table_rows[i]) begin
      pinned_q.push_back({table_rows[i].pinned, table_rows[i].rd_val});
      send(table_rows[i].it);
    end

    // Random part: mostly well-formed transfers with random content
    first_accepted = n_accepted;
    while (n_accepted - first_accepted < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1: card_in_burst();
        2, 3: card_out_burst();
        4: fill_and_drain();
        5, 6: command_exchange();
        7, 8: register_poke();
        default: noise_item();
      endcase
    end
    in_bus.valid <= 1'b0;

    // Drain outstanding results, then allow a few quiet cycles
    while (expected_q.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Covered %0d transfers: %0d card words moved, %0d commands sent,",
             n_accepted, n_words, n_cmds);
    $display("%0d FIFO overrun/underrun events, %0d results checked.",
             n_fifo_err, n_results);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
